@@ rtl/core/tac_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tac_pkg
// Shared constants, opcode codes and result types of the accumulator core.
// ----------------------------------------------------------------------------
package tac_pkg;

	// Program ROM size and data RAM geometry
	localparam int ROM_DEPTH = 256;
	localparam int RAM_DEPTH = 128;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);
	localparam int PC_W      = 9;

	// Widths of the stream words
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	// Opcodes (upper nibble of the instruction)
	typedef enum logic [3:0] {
		OP_LD  = 4'h0,
		OP_ST  = 4'h2,
		OP_MOV = 4'h4,
		OP_LDI = 4'h5,
		OP_ADD = 4'h6,
		OP_SUB = 4'h7,
		OP_SHL = 4'h8,
		OP_SHR = 4'h9,
		OP_TST = 4'hA,
		OP_OUT = 4'hC,
		OP_IN  = 4'hD,
		OP_BZ  = 4'hE,
		OP_JMP = 4'hF
	} op_t;

	// One result word
	typedef struct packed {
		logic            halted;
		logic            overflow_flag;
		logic            zero_flag;
		logic [7:0]      out_value;
		logic            out_valid;
		logic [PC_W-1:0] next_pc;
	} res_t;

endpackage : tac_pkg
`default_nettype wire

@@ rtl/core/tac_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tac_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, hold data when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule : tac_ram
`default_nettype wire

@@ rtl/core/tac_exec.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tac_exec
// Execute unit: register file, flags, counter, data RAM and result stage.
// Loads read the RAM at accept and commit r0 and Z in the following cycle; the
// following word sees the load data through forwarding.
// ----------------------------------------------------------------------------
module tac_exec import tac_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] instr_byte,
	input  wire logic [7:0] ext_in,
	output logic            res_valid,
	input  wire logic       res_ready,
	output res_t            res
);

	logic [7:0]      regs_q [4];
	logic [7:0]      regs_d [4];
	logic [7:0]      reg_eff [4];
	logic            z_q, z_d, z_eff;
	logic            o_q, o_d;
	logic            h_q, h_d;
	logic [PC_W-1:0] pc_q, pc_d;
	logic [RAM_DEPTH-1:0] vld_q;

	logic            s1_v_q;
	res_t            res_s1;
	logic            ld_pend_s1;
	logic            ld_vld_s1;

	logic            accept;
	logic            s1_move;
	op_t             op;
	logic [1:0]      rx, ry;
	logic [7:0]      a_rx, a_ry;
	logic [8:0]      sum9, diff9;
	logic            advance;
	logic            ld_issue;
	logic            st_we;
	logic [7:0]      ram_rdata;
	logic [7:0]      ldata;
	logic            outv;
	logic [7:0]      outval;
	res_t            res_d;

	assign s1_move  = s1_v_q && res_ready;
	assign in_ready = !s1_v_q || res_ready;
	assign accept   = in_valid && in_ready;

	assign op = op_t'(instr_byte[7:4]);
	assign rx = instr_byte[3:2];
	assign ry = instr_byte[1:0];

	// Forward load data that is not yet committed
	assign ldata = ld_vld_s1 ? ram_rdata : 8'h00;
	assign z_eff = ld_pend_s1 ? (ldata == 8'h00) : z_q;
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			reg_eff[i] = regs_q[i];
		end
		if (ld_pend_s1) begin
			reg_eff[0] = ldata;
		end
	end

	assign a_rx  = reg_eff[rx];
	assign a_ry  = reg_eff[ry];
	assign sum9  = {1'b0, a_rx} + {1'b0, a_ry};
	assign diff9 = {1'b0, a_rx} - {1'b0, a_ry};

	// Execute the accepted word
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			regs_d[i] = reg_eff[i];
		end
		z_d      = z_eff;
		o_d      = o_q;
		h_d      = h_q;
		pc_d     = pc_q;
		advance  = 1'b0;
		ld_issue = 1'b0;
		st_we    = 1'b0;
		outv     = 1'b0;
		outval   = 8'h00;
		if (accept && !h_q) begin
			if (pc_q >= PC_W'(ROM_DEPTH)) begin
				h_d = 1'b1;
			end else begin
				advance = 1'b1;
				unique case (op)
					OP_LD: begin
						ld_issue = a_ry[7];
					end
					OP_ST: begin
						if (a_ry[7]) begin
							st_we = 1'b1;
							z_d   = (reg_eff[0] == 8'h00);
						end
					end
					OP_MOV: begin
						regs_d[ry] = a_rx;
						z_d        = (a_rx == 8'h00);
					end
					OP_LDI: begin
						regs_d[0] = {4'h0, instr_byte[3:0]};
						z_d       = (instr_byte[3:0] == 4'h0);
					end
					OP_ADD: begin
						regs_d[rx] = sum9[7:0];
						z_d        = (sum9[7:0] == 8'h00);
						o_d        = sum9[8];
					end
					OP_SUB: begin
						regs_d[rx] = diff9[7:0];
						z_d        = (diff9[7:0] == 8'h00);
						o_d        = diff9[8];
					end
					OP_SHL: begin
						regs_d[ry] = {a_ry[3:0], 4'h0};
					end
					OP_SHR: begin
						regs_d[ry] = {4'h0, a_ry[7:4]};
					end
					OP_TST: begin
						z_d = (a_ry == 8'h00);
					end
					OP_OUT: begin
						outv   = 1'b1;
						outval = a_ry;
					end
					OP_IN: begin
						regs_d[ry] = ext_in;
						z_d        = (ext_in == 8'h00);
					end
					OP_BZ, OP_JMP: begin
						if (op == OP_JMP || z_eff) begin
							advance = 1'b0;
							if ({1'b0, a_ry} < PC_W'(ROM_DEPTH)) begin
								pc_d = {1'b0, a_ry};
							end else begin
								h_d = 1'b1;
							end
						end
					end
					default: begin
						advance = 1'b0;
						h_d     = 1'b1;
					end
				endcase
			end
			if (advance) begin
				pc_d = pc_q + PC_W'(1);
			end
		end
	end

	// Assemble the result word; a load patches Z in the following cycle
	always_comb begin
		res_d.next_pc       = pc_d;
		res_d.out_valid     = outv;
		res_d.out_value     = outval;
		res_d.zero_flag     = z_d;
		res_d.overflow_flag = o_d;
		res_d.halted        = h_d;
	end

	// Data RAM
	tac_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (a_ry[RAM_AW-1:0]),
		.wdata (reg_eff[0]),
		.re    (ld_issue),
		.raddr (a_ry[RAM_AW-1:0]),
		.rdata (ram_rdata)
	);

	// Architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				regs_q[i] <= 8'h00;
			end
			z_q   <= 1'b0;
			o_q   <= 1'b0;
			h_q   <= 1'b0;
			pc_q  <= '0;
			vld_q <= '0;
		end else begin
			for (int i = 0; i < 4; i++) begin
				regs_q[i] <= regs_d[i];
			end
			z_q  <= z_d;
			o_q  <= o_d;
			h_q  <= h_d;
			pc_q <= pc_d;
			if (st_we) begin
				vld_q[a_ry[RAM_AW-1:0]] <= 1'b1;
			end
		end
	end

	// Load tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_pend_s1 <= 1'b0;
			ld_vld_s1  <= 1'b0;
		end else begin
			ld_pend_s1 <= ld_issue;
			if (ld_issue) begin
				ld_vld_s1 <= vld_q[a_ry[RAM_AW-1:0]];
			end
		end
	end

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (accept) begin
			s1_v_q <= 1'b1;
		end else if (s1_move) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
		end else if (ld_pend_s1) begin
			res_s1.zero_flag <= (ldata == 8'h00);
		end
	end

	always_comb begin
		res = res_s1;
		if (ld_pend_s1) begin
			res.zero_flag = (ldata == 8'h00);
		end
	end
	assign res_valid = s1_v_q;

	// Halt is sticky
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		h_q |=> h_q)
		else $error("halt flag cleared");

	// Counter never passes one beyond the ROM
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= PC_W'(ROM_DEPTH))
		else $error("program counter out of range");

	// A pending load always has its result in the stage
	a_ld_in_s1: assert property (@(posedge clk) disable iff (!arst_n)
		ld_pend_s1 |-> s1_v_q)
		else $error("load pending without result");

	// A halted block keeps its counter
	a_halt_pc: assert property (@(posedge clk) disable iff (!arst_n)
		h_q |=> pc_q == $past(pc_q))
		else $error("counter moved while halted");

endmodule : tac_exec
`default_nettype wire

@@ rtl/core/tac_outq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tac_outq
// Output register of the result stream; packs the result into the word.
// ----------------------------------------------------------------------------
module tac_outq import tac_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  res_valid,
	output logic                       res_ready,
	input  wire res_t                  res,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	logic out_v_q;
	res_t out_q;

	assign res_ready = !out_v_q || m_tready;

	// Hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_ready) begin
			out_v_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {3'b000, out_q.halted, out_q.overflow_flag, out_q.zero_flag,
		out_q.out_value, out_q.out_valid, out_q.next_pc};

endmodule : tac_outq
`default_nettype wire

@@ rtl/core/tiny_accumulator_cpu_execute.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tiny_accumulator_cpu_execute
// Execute stage of a small accumulator CPU, one instruction per input word.
// Each word passes through the result stage and then the output register.
// Throughput: one word per cycle while the output is not stalled; loads forward
// RAM data to the next word. The result stage waits out the registered RAM
// read; the output register follows it.
// Reset: asynchronous; clears registers, flags, counter, halt and RAM valid
// bits at once, so the RAM reads as zero with no clearing pass.
// ----------------------------------------------------------------------------
module tiny_accumulator_cpu_execute import tac_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // instr_byte[7:0], ext_in[15:8]
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// next_pc[8:0], out_valid[9], out_value[17:10], zero_flag[18],
	// overflow_flag[19], halted[20], zero fill[23:21]
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	logic res_valid;
	logic res_ready;
	res_t res;

	// Execution core
	tac_exec u_exec (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.instr_byte (s_tdata[7:0]),
		.ext_in     (s_tdata[15:8]),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// Output register
	tac_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule : tiny_accumulator_cpu_execute
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the accumulator core execute stage. A directed
// program walks every opcode, the flag corner cases and the counter extremes,
// then a long random program runs with the counter kept inside the ROM, and
// the run ends by halting the core and feeding words that must change nothing.
// Every result word is compared with an in-bench model, or with the table's want.
// ----------------------------------------------------------------------------
module tb_top;
	import tac_pkg::*;

	localparam int          RANDOM_INSTRS = 700;
	localparam int          CYCLE_LIMIT   = 200000;
	localparam int          DRAIN_CYCLES  = 8;
	localparam int          PC_GUARD      = 240;
	localparam logic [7:0]  RAM_BASE      = 8'h80;

	// Opcodes the core does not define
	localparam logic [3:0] OP_BAD_1 = 4'h1;
	localparam logic [3:0] OP_BAD_3 = 4'h3;
	localparam logic [3:0] OP_BAD_B = 4'hB;
	localparam logic [3:0] BAD_OPS [0:2] = '{OP_BAD_1, OP_BAD_3, OP_BAD_B};

	localparam op_t LEGAL_OPS [0:12] = '{OP_LD, OP_ST, OP_MOV, OP_LDI, OP_ADD, OP_SUB,
		OP_SHL, OP_SHR, OP_TST, OP_OUT, OP_IN, OP_BZ, OP_JMP};

	typedef struct packed {
		logic [7:0] instr;
		logic [7:0] ext;
		logic       typed;
		res_t       want;
	} prog_row_t;

	// Directed program; the want column is used only where typed is set.
	// Result order: halted, overflow, zero, out_value, out_valid, next_pc.
	localparam prog_row_t DIRECTED [0:25] = '{
		'{{OP_LDI, 4'hF}, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 9'd1}},
		'{{OP_LDI, 4'h0}, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 9'd2}},
		'{{OP_OUT, 4'h0}, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b1, 8'h00, 1'b1, 9'd3}},
		'{{OP_IN,  4'h1}, 8'hFF, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 9'd4}},
		'{{OP_IN,  4'h2}, 8'h80, 1'b0, '0},
		'{{OP_IN,  4'h3}, 8'h01, 1'b0, '0},
		// 0xFF + 1: carry out and zero
		'{{OP_ADD, 4'h7}, 8'h00, 1'b1, '{1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 9'd7}},
		// 0 - 1: borrow
		'{{OP_SUB, 4'h7}, 8'h00, 1'b1, '{1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 9'd8}},
		'{{OP_LDI, 4'h5}, 8'h00, 1'b0, '0},
		'{{OP_ST,  4'h2}, 8'h00, 1'b0, '0},
		// store and load through an address below the RAM window
		'{{OP_ST,  4'hF}, 8'h00, 1'b0, '0},
		'{{OP_LD,  4'h7}, 8'h00, 1'b0, '0},
		'{{OP_LDI, 4'h0}, 8'h00, 1'b0, '0},
		'{{OP_LD,  4'h2}, 8'h00, 1'b0, '0},
		'{{OP_MOV, 4'h4}, 8'h00, 1'b0, '0},
		'{{OP_SHL, 4'h0}, 8'h00, 1'b0, '0},
		'{{OP_SHR, 4'h0}, 8'h00, 1'b0, '0},
		'{{OP_OUT, 4'hD}, 8'h00, 1'b0, '0},
		// branch on zero, not taken
		'{{OP_BZ,  4'h3}, 8'h00, 1'b0, '0},
		'{{OP_SUB, 4'hB}, 8'h00, 1'b0, '0},
		'{{OP_SUB, 4'h5}, 8'h00, 1'b0, '0},
		'{{OP_TST, 4'h1}, 8'h00, 1'b0, '0},
		// branch on zero, taken
		'{{OP_BZ,  4'h3}, 8'h00, 1'b0, '0},
		'{{OP_IN,  4'h2}, 8'hFF, 1'b0, '0},
		// jump to the last ROM address, then back low
		'{{OP_JMP, 4'h2}, 8'h00, 1'b0, '0},
		'{{OP_JMP, 4'h3}, 8'h00, 1'b0, '0}
	};

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;  // instr_byte[7:0], ext_in[15:8]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // next_pc, out_valid, out_value, flags, halted

	// Core state as the bench sees it
	logic [7:0]      gpr [0:3];
	logic [7:0]      ram [0:RAM_DEPTH-1];
	logic [PC_W-1:0] cpu_pc;
	logic            zero_f, ovf_f, halt_f;

	res_t pending_results [$];
	int   mismatches  = 0;
	int   cycle_count = 0;
	int   send_gap    = 0;
	int   recv_wait   = 0;
	bit   quiet       = 1'b0;

	tiny_accumulator_cpu_execute DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Both sides share one quiet mode so that bursts run without any idling
	function automatic int draw_wait();
		return quiet ? 0 : $urandom_range(0, 7);
	endfunction

	// Execute one instruction on the bench state and return its result word
	function automatic res_t exec_instr(input logic [7:0] instr, input logic [7:0] ext);
		op_t        op;
		logic [1:0] rx, ry;
		logic [7:0] a;
		logic [8:0] sum;
		logic       adv;
		res_t       r;
		r   = '0;
		adv = 1'b1;
		op  = op_t'(instr[7:4]);
		rx  = instr[3:2];
		ry  = instr[1:0];
		if (!halt_f) begin
			if (cpu_pc >= ROM_DEPTH) begin
				halt_f = 1'b1;
				adv    = 1'b0;
			end else begin
				case (op)
					OP_LD: begin
						a = gpr[ry];
						if (a >= RAM_BASE) begin
							gpr[0] = ram[a[RAM_AW-1:0]];
							zero_f = (gpr[0] == 8'h00);
						end
					end
					OP_ST: begin
						a = gpr[ry];
						if (a >= RAM_BASE) begin
							ram[a[RAM_AW-1:0]] = gpr[0];
							zero_f = (gpr[0] == 8'h00);
						end
					end
					OP_MOV: begin
						a       = gpr[rx];
						gpr[ry] = a;
						zero_f  = (a == 8'h00);
					end
					OP_LDI: begin
						gpr[0] = {4'h0, instr[3:0]};
						zero_f = (instr[3:0] == 4'h0);
					end
					OP_ADD: begin
						sum     = {1'b0, gpr[rx]} + {1'b0, gpr[ry]};
						gpr[rx] = sum[7:0];
						zero_f  = (sum[7:0] == 8'h00);
						ovf_f   = sum[8];
					end
					OP_SUB: begin
						ovf_f   = (gpr[rx] < gpr[ry]);
						a       = gpr[rx] - gpr[ry];
						gpr[rx] = a;
						zero_f  = (a == 8'h00);
					end
					OP_SHL: gpr[ry] = {gpr[ry][3:0], 4'h0};
					OP_SHR: gpr[ry] = {4'h0, gpr[ry][7:4]};
					OP_TST: zero_f = (gpr[ry] == 8'h00);
					OP_OUT: begin
						r.out_valid = 1'b1;
						r.out_value = gpr[ry];
					end
					OP_IN: begin
						gpr[ry] = ext;
						zero_f  = (ext == 8'h00);
					end
					OP_BZ, OP_JMP: begin
						if (op == OP_JMP || zero_f) begin
							adv = 1'b0;
							if (int'(gpr[ry]) < ROM_DEPTH) cpu_pc = {1'b0, gpr[ry]};
							else halt_f = 1'b1;
						end
					end
					default: begin
						halt_f = 1'b1;
						adv    = 1'b0;
					end
				endcase
			end
			if (adv) cpu_pc = cpu_pc + 1'b1;
		end
		r.next_pc       = cpu_pc;
		r.zero_flag     = zero_f;
		r.overflow_flag = ovf_f;
		r.halted        = halt_f;
		return r;
	endfunction

	// Choose a legal instruction; near the ROM end force a jump back low or an LDI
	function automatic logic [7:0] pick_instr();
		logic [3:0] low;
		op_t        op;
		int         start;
		int         k;
		low = 4'($urandom);
		if (cpu_pc >= PC_GUARD) begin
			start = $urandom_range(0, 3);
			for (int i = 0; i < 4; i++) begin
				k = (start + i) % 4;
				if (gpr[k] < PC_GUARD) return {OP_JMP, low[3:2], 2'(k)};
			end
			return {OP_LDI, low};
		end
		op = LEGAL_OPS[$urandom_range(0, 12)];
		// keep branch targets clear of the ROM end
		if ((op == OP_JMP || op == OP_BZ) && gpr[low[1:0]] >= PC_GUARD) op = OP_OUT;
		return {op, low};
	endfunction

	// Present one word, wait for it to be taken, then record its result
	task automatic feed_instr(input logic [7:0] instr, input logic [7:0] ext,
			input logic typed, input res_t want);
		res_t model;
		if (send_gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (send_gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {ext, instr};
		do @(posedge clk); while (!s_tready);
		model = exec_instr(instr, ext);
		pending_results.push_back(typed ? want : model);
		send_gap = draw_wait();
	endtask

	task automatic report_error(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("ERROR at cycle %0d: %s", cycle_count, msg);
	endtask

	// Stimulus
	initial begin
		int end_kind;
		for (int i = 0; i < 4; i++) gpr[i] = 8'h00;
		for (int i = 0; i < RAM_DEPTH; i++) ram[i] = 8'h00;
		cpu_pc = '0;
		zero_f = 1'b0;
		ovf_f  = 1'b0;
		halt_f = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		send_gap = draw_wait();

		foreach (DIRECTED[i])
			feed_instr(DIRECTED[i].instr, DIRECTED[i].ext, DIRECTED[i].typed, DIRECTED[i].want);

		for (int i = 0; i < RANDOM_INSTRS; i++) begin
			if ($urandom_range(0, 63) == 0) quiet = !quiet;
			feed_instr(pick_instr(), 8'($urandom), 1'b0, '0);
		end
		quiet = 1'b0;

		// Halt the core: an undefined opcode, or running the counter off the ROM
		end_kind = $urandom_range(0, 3);
		if (end_kind < 3) begin
			feed_instr({BAD_OPS[end_kind], 4'($urandom)}, 8'($urandom), 1'b0, '0);
		end else begin
			feed_instr({OP_IN, 4'h1}, 8'hFF, 1'b0, '0);
			feed_instr({OP_JMP, 4'h1}, 8'h00, 1'b0, '0);
			feed_instr({OP_LDI, 4'($urandom)}, 8'h00, 1'b0, '0);
		end
		// Once halted, nothing may change
		repeat (8) feed_instr(8'($urandom), 8'($urandom), 1'b0, '0);
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("** tiny_accumulator_cpu_execute: PASSED **");
		end else begin
			$display("** tiny_accumulator_cpu_execute: FAILED **");
		end
		$finish;
	end

	// Result side: check each word taken, then stall for a drawn number of cycles
	initial begin
		res_t got, want;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata[$bits(res_t)-1:0]);
				if (pending_results.size() == 0) begin
					report_error($sformatf("result word %h with nothing expected", m_tdata));
				end else begin
					want = pending_results.pop_front();
					if (got !== want)
						report_error($sformatf({"pc %0d/%0d out_valid %b/%b out_value %h/%h ",
							"zero %b/%b ovf %b/%b halted %b/%b (expected/actual)"},
							want.next_pc, got.next_pc, want.out_valid, got.out_valid,
							want.out_value, got.out_value, want.zero_flag, got.zero_flag,
							want.overflow_flag, got.overflow_flag, want.halted, got.halted));
				end
				recv_wait = draw_wait();
				if (recv_wait > 0) m_tready <= 1'b0;
			end else if (!m_tready && arst_n) begin
				if (recv_wait > 0) recv_wait--;
				if (recv_wait == 0) m_tready <= 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** tiny_accumulator_cpu_execute: FAILED **");
			$finish;
		end
	end

endmodule
